@@ design/sha256_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 digest block.
// Used by sha256_core and sha256_message_digest; depends on nothing else.
package sha256_pkg;

    localparam int WORD_W    = 32;
    localparam int HASH_N    = 8;
    localparam int BLOCK_N   = 16;
    localparam int ROUND_N   = 64;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] BLOCK_END = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP_DATA,
        ST_PAD,
        ST_COMP_PAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       byte_we;
        logic [5:0] byte_pos;
        logic [7:0] byte_val;
        logic       start;
        logic       hash_init;
    } core_ctrl_t;

    typedef struct packed {
        logic done;
    } core_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] hash_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        hash_iv = v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage

@@ design/sha256_core.sv @@
// SHA-256 compression engine: block window, working variables and hash words.
// One round per cycle over a sliding 16-word schedule window; uses sha256_pkg.
module sha256_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256_pkg::core_ctrl_t   ctrl,
    output sha256_pkg::core_stat_t   stat,
    output logic [7:0][31:0]         hash
);

    logic [31:0] win_reg  [sha256_pkg::BLOCK_N];
    logic [31:0] var_reg  [sha256_pkg::HASH_N];
    logic [31:0] hash_reg [sha256_pkg::HASH_N];
    logic [31:0] hash_next [sha256_pkg::HASH_N];
    logic [5:0]  round_reg, round_next;
    logic        active_reg, active_next;
    logic        fin_reg, fin_next;

    logic [31:0] t1, t2, ch, mj, sched_new, byte_word;
    logic [3:0]  byte_wsel;

    always_comb
    begin
        ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        mj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]);
        t1 = var_reg[7] + sha256_pkg::big_sig1(var_reg[4]) + ch
             + sha256_pkg::round_k(round_reg) + win_reg[0];
        t2 = sha256_pkg::big_sig0(var_reg[0]) + mj;
        // schedule word sixteen ahead of the one consumed this round
        sched_new = win_reg[0] + sha256_pkg::small_sig0(win_reg[1]) + win_reg[9]
                    + sha256_pkg::small_sig1(win_reg[14]);
    end

    // big-endian byte placement; the first byte of a word clears it
    always_comb
    begin
        byte_wsel = ctrl.byte_pos[5:2];
        case (ctrl.byte_pos[1:0])
            2'd0:    byte_word = {ctrl.byte_val, 24'h0};
            2'd1:    byte_word = win_reg[byte_wsel] | {8'h0, ctrl.byte_val, 16'h0};
            2'd2:    byte_word = win_reg[byte_wsel] | {16'h0, ctrl.byte_val, 8'h0};
            2'd3:    byte_word = win_reg[byte_wsel] | {24'h0, ctrl.byte_val};
            default: byte_word = 32'h0;
        endcase
    end

    always_comb
    begin
        round_next  = round_reg;
        active_next = active_reg;
        fin_next    = 1'b0;
        for (int i = 0; i < sha256_pkg::HASH_N; i++)
        begin
            hash_next[i] = hash_reg[i];
            if (ctrl.hash_init)
                hash_next[i] = sha256_pkg::hash_iv(3'(i));
            else if (fin_reg)
                hash_next[i] = hash_reg[i] + var_reg[i];
        end
        if (ctrl.start)
        begin
            active_next = 1'b1;
            round_next  = 6'd0;
        end
        else if (active_reg)
        begin
            round_next = round_reg + 6'd1;
            if (round_reg == sha256_pkg::BLOCK_END)
            begin
                active_next = 1'b0;
                fin_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg  <= 6'd0;
            active_reg <= 1'b0;
            fin_reg    <= 1'b0;
            for (int i = 0; i < sha256_pkg::HASH_N; i++)
                hash_reg[i] <= sha256_pkg::hash_iv(3'(i));
        end
        else
        begin
            round_reg  <= round_next;
            active_reg <= active_next;
            fin_reg    <= fin_next;
            for (int i = 0; i < sha256_pkg::HASH_N; i++)
                hash_reg[i] <= hash_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < sha256_pkg::HASH_N; i++)
                var_reg[i] <= hash_reg[i];
        end
        else if (active_reg)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end

        if (active_reg)
        begin
            for (int i = 0; i < sha256_pkg::BLOCK_N - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[sha256_pkg::BLOCK_N - 1] <= sched_new;
        end
        else if (ctrl.byte_we)
        begin
            win_reg[byte_wsel] <= byte_word;
        end
    end

    always_comb
    begin
        stat.done = fin_reg;
        for (int i = 0; i < sha256_pkg::HASH_N; i++)
            hash[i] = hash_reg[i];
    end

endmodule

@@ design/sha256_message_digest.sv @@
// SHA-256 message digest, top level: byte intake, padding sequencer, digest output.
// Instantiates sha256_core; uses sha256_pkg.
// A byte item is taken in ST_IDLE; a byte that completes a block starts a compression
// (load, the rounds on the core's single round unit, then hash update) before the next item.
// A last item pads one byte per cycle and compresses one or two blocks, then the
// eight digest words leave one per cycle as the consumer takes them.
// Reset (rst_n low, asynchronous) restores the initial hash and clears length and
// position.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha256_pkg::state_t     state_reg, state_next;
    sha256_pkg::core_ctrl_t core_ctrl;
    sha256_pkg::core_stat_t core_stat;
    logic [7:0][31:0]       hash;

    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic        last_pend_reg, last_pend_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_phase_reg, len_phase_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic        len_done_reg, len_done_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        in_accept;

    sha256_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .stat  (core_stat),
        .hash  (hash)
    );

    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        last_pend_next = last_pend_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        len_idx_next   = len_idx_reg;
        len_done_next  = len_done_reg;
        out_idx_next   = out_idx_reg;

        core_ctrl           = '0;
        core_ctrl.byte_pos  = pos_reg;

        s_tready = (state_reg == sha256_pkg::ST_IDLE);
        m_tvalid = (state_reg == sha256_pkg::ST_OUT);
        m_tdata  = hash[out_idx_reg];
        m_tuser  = out_idx_reg;
        m_tlast  = (out_idx_reg == 3'd7);

        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    last_pend_next = s_tlast;
                    if (s_tuser[0])
                    begin
                        core_ctrl.byte_we  = 1'b1;
                        core_ctrl.byte_val = s_tdata;
                        len_next = len_reg + 64'd8;
                        pos_next = pos_reg + 6'd1;
                    end
                    if (s_tuser[0] && pos_reg == sha256_pkg::BLOCK_END)
                    begin
                        core_ctrl.start = 1'b1;
                        state_next = sha256_pkg::ST_COMP_DATA;
                    end
                    else if (s_tlast)
                    begin
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        len_idx_next   = 3'd0;
                        len_done_next  = 1'b0;
                        state_next     = sha256_pkg::ST_PAD;
                    end
                end
            end

            sha256_pkg::ST_COMP_DATA:
            begin
                if (core_stat.done)
                begin
                    if (last_pend_reg)
                    begin
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        len_idx_next   = 3'd0;
                        len_done_next  = 1'b0;
                        state_next     = sha256_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end

            sha256_pkg::ST_PAD:
            begin
                core_ctrl.byte_we = 1'b1;
                pos_next = pos_reg + 6'd1;
                if (pad_first_reg)
                begin
                    core_ctrl.byte_val = sha256_pkg::PAD_BYTE;
                    pad_first_next = 1'b0;
                end
                else if (!len_phase_reg && pos_reg != sha256_pkg::LEN_POS)
                begin
                    core_ctrl.byte_val = 8'h00;
                end
                else
                begin
                    // length goes out most significant byte first
                    core_ctrl.byte_val = len_reg[{~len_idx_reg, 3'b000} +: 8];
                    len_phase_next = 1'b1;
                    len_idx_next   = len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                        len_done_next = 1'b1;
                end
                if (pos_reg == sha256_pkg::BLOCK_END)
                begin
                    core_ctrl.start = 1'b1;
                    state_next = sha256_pkg::ST_COMP_PAD;
                end
            end

            sha256_pkg::ST_COMP_PAD:
            begin
                if (core_stat.done)
                    state_next = len_done_reg ? sha256_pkg::ST_OUT : sha256_pkg::ST_PAD;
            end

            sha256_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        core_ctrl.hash_init = 1'b1;
                        len_next   = 64'd0;
                        pos_next   = 6'd0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_IDLE;
            pos_reg       <= 6'd0;
            len_reg       <= 64'd0;
            last_pend_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            len_idx_reg   <= 3'd0;
            len_done_reg  <= 1'b0;
            out_idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            last_pend_reg <= last_pend_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            len_idx_reg   <= len_idx_next;
            len_done_reg  <= len_done_next;
            out_idx_reg   <= out_idx_next;
        end
    end

endmodule

@@ design/sha256_checker.sv @@
// Port-level checks for sha256_message_digest, attached by bind.
// Sees only the top level's ports; depends on nothing else.
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // no intake while the digest is going out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest words pending");

    // digest words go out in order without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tuser == 3'($past(m_tuser) + 3'd1)))
        else $error("digest word sequence broken");

    // the flagged word ends the burst and the input is ready again
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("output did not end after last word");

    // an empty, unmarked item leaves the block ready at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && !s_tlast) |=> s_tready)
        else $error("idle item stalled the input");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output item changed");

endmodule

bind sha256_message_digest sha256_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
